FILE: sv/prfl_pkg.sv
package prfl_pkg;

  // fixed field widths of the ports
  localparam int PAGE_W = 8;
  localparam int SLOT_W = 3;
  localparam int HITS_W = 16;
  localparam int CFG_W  = 4;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  // configuration register indexes
  typedef enum logic [0:0] {
    REG_POLICY = 1'b0,
    REG_FRAMES = 1'b1
  } cfg_reg_t;

  // replacement policy codes
  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  // per-cell control from the top level
  typedef struct packed {
    logic step;       // a reference is transferred this cycle
    logic lru_hit;    // hit with lru policy
    logic full_miss;  // miss with every frame in use
    logic clear;      // drop this entry after a frame count change
    logic active;     // cell index below the effective frame count
  } cell_ctl_t;

endpackage

FILE: sv/prfl_cell.sv
module prfl_cell #(
  parameter int PW = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  prfl_pkg::cell_ctl_t ctl,
  input  logic [PW-1:0]     new_page,
  input  logic [PW-1:0]     above_page,
  input  logic              above_valid,
  input  logic              below_valid,
  input  logic              below_hit,
  output logic [PW-1:0]     page_q,
  output logic              valid_q,
  output logic              match,
  output logic              hit_up,
  output logic              top,
  output logic              free
);
  import prfl_pkg::*;

  logic move;
  logic fill;

  assign match  = valid_q && (page_q == new_page);
  assign hit_up = below_hit || match;
  assign top    = valid_q && !above_valid;
  assign free   = !valid_q && below_valid && ctl.active;
  assign move   = (ctl.lru_hit && hit_up) || ctl.full_miss;
  // every resident page sits below the free cell, so its below_hit is the hit
  assign fill   = free && !below_hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= 1'b0;
    end else if (ctl.clear) begin
      valid_q <= 1'b0;
    end else if (ctl.step && fill && !ctl.full_miss) begin
      valid_q <= 1'b1;
    end
  end

  // shift down from the neighbor, or take the new page at the top of the run
  always_ff @(posedge clk) begin
    if (ctl.step) begin
      if (valid_q && move) begin
        page_q <= above_valid ? above_page : new_page;
      end else if (fill) begin
        page_q <= new_page;
      end
    end
  end

endmodule

FILE: sv/page_replace_fifo_lru_core.sv
// page replacement stack, fifo or lru, one page reference per transfer
// results appear with done in the cycle after start is taken
// throughput: one reference per cycle; busy stays low, the whole cell row updates on each transfer
// reset: stack empty, hit count zero, lru policy, eight frames requested
// results are strobed for one cycle on done; the receiver cannot stall
module page_replace_fifo_lru_core #(
  parameter int FRAMES     = 8,
  parameter int PAGE_COUNT = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [prfl_pkg::PAGE_W-1:0]     page,
  input  logic                            cfg_we,
  input  prfl_pkg::cfg_reg_t              cfg_idx,
  input  logic [prfl_pkg::CFG_W-1:0]      cfg_data,
  output logic                            done,
  output logic                            hit,
  output logic [prfl_pkg::SLOT_W-1:0]     slot,
  output logic                            evicted_valid,
  output logic [prfl_pkg::PAGE_W-1:0]     evicted_page,
  output logic [prfl_pkg::HITS_W-1:0]     hit_total
);
  import prfl_pkg::*;

  // stored page width: the port is 8 bits, the page space may be smaller
  localparam int PW    = (PAGE_COUNT >= (1 << PAGE_W)) ? PAGE_W : $clog2(PAGE_COUNT);
  localparam int SW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CNT_W = $clog2(FRAMES + 1);
  localparam int TAB_N = 1 << PAGE_W;

  // configuration registers
  logic              policy;
  logic [CFG_W-1:0]  frames_req;

  // page reduction table, modulo a constant worked out at elaboration
  logic [PW-1:0] mod_tab [TAB_N];
  logic [PW-1:0] ref_page;

  // the cell row
  cell_ctl_t        ctl      [FRAMES];
  logic [PW-1:0]    cell_pg  [FRAMES];
  logic [FRAMES:0]  valid_chain;   // [i] is the valid of cell i-1, [0] tied high
  logic [FRAMES:0]  hit_chain;     // hit at or below, rippled upward
  logic [FRAMES-1:0] match_vec;
  logic [FRAMES-1:0] top_vec;
  logic [FRAMES-1:0] free_vec;

  logic              step;
  logic              ref_hit;
  logic              free_any;
  logic              lru_hit;
  logic              full_miss;
  logic              frames_wr;
  logic [CNT_W-1:0]  n_cur;
  logic [CNT_W-1:0]  n_new;
  logic [FRAMES-1:0] sel_vec;
  logic [SW-1:0]     sel_idx;
  logic [SLOT_W+SW-1:0] slot_wide;
  logic [HITS_W-1:0] hit_cnt;
  logic [HITS_W-1:0] hit_cnt_next;

  // clamp a requested frame count into one to FRAMES
  function automatic logic [CNT_W-1:0] eff_frames(input logic [CFG_W-1:0] x);
    logic [CNT_W-1:0] r;
    if (x == '0) begin
      r = CNT_W'(1);
    end else if (int'(x) > FRAMES) begin
      r = CNT_W'(FRAMES);
    end else begin
      r = CNT_W'(x);
    end
    return r;
  endfunction

  // a new reference can start every cycle
  assign busy = 1'b0;
  assign step = start && !busy;

  for (genvar v = 0; v < TAB_N; v++) begin : g_tab
    assign mod_tab[v] = PW'(v % PAGE_COUNT);
  end
  assign ref_page = mod_tab[page];

  // configuration writes, only while idle: the user keeps to this, the block itself does not enforce it
  assign frames_wr = cfg_we && (cfg_idx == REG_FRAMES);
  assign n_cur     = eff_frames(frames_req);
  assign n_new     = eff_frames(cfg_data);

  always_ff @(posedge clk) begin
    if (rst) begin
      policy     <= POLICY_LRU;
      frames_req <= CFG_W'(8);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_POLICY: policy     <= cfg_data[0];
        REG_FRAMES: frames_req <= cfg_data;
        default:    ;
      endcase
    end
  end

  // global decisions from the row
  assign ref_hit   = hit_chain[FRAMES];
  assign free_any  = |free_vec;
  assign lru_hit   = ref_hit && (policy == POLICY_LRU);
  assign full_miss = !ref_hit && !free_any;

  assign valid_chain[0] = 1'b1;
  assign hit_chain[0]   = 1'b0;

  for (genvar i = 0; i < FRAMES; i++) begin : g_cell
    logic [PW-1:0] above_pg;
    logic          above_vl;

    if (i == FRAMES - 1) begin : g_last
      assign above_pg = '0;
      assign above_vl = 1'b0;
    end else begin : g_mid
      assign above_pg = cell_pg[i+1];
      assign above_vl = valid_chain[i+2];
    end

    assign ctl[i].step      = step;
    assign ctl[i].lru_hit   = lru_hit;
    assign ctl[i].full_miss = full_miss;
    // entries at or above the new frame count are dropped without report
    assign ctl[i].clear     = frames_wr && !(i < int'(n_new));
    assign ctl[i].active    = i < int'(n_cur);

    prfl_cell #(
      .PW (PW)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl[i]),
      .new_page    (ref_page),
      .above_page  (above_pg),
      .above_valid (above_vl),
      .below_valid (valid_chain[i]),
      .below_hit   (hit_chain[i]),
      .page_q      (cell_pg[i]),
      .valid_q     (valid_chain[i+1]),
      .match       (match_vec[i]),
      .hit_up      (hit_chain[i+1]),
      .top         (top_vec[i]),
      .free        (free_vec[i])
    );
  end

  // slot after this reference:
  //   fifo hit keeps the matching slot, lru hit and full miss end at the top
  //   of the run, a fill takes the first free slot
  always_comb begin
    if (ref_hit) begin
      sel_vec = (policy == POLICY_LRU) ? top_vec : match_vec;
    end else if (free_any) begin
      sel_vec = free_vec;
    end else begin
      sel_vec = top_vec;
    end
  end

  // one-hot to index, the selected vector has a single bit set
  always_comb begin
    sel_idx = '0;
    for (int k = 0; k < FRAMES; k++) begin
      if (sel_vec[k]) begin
        sel_idx = sel_idx | SW'(k);
      end
    end
  end

  assign slot_wide = {{SLOT_W{1'b0}}, sel_idx};

  // saturating hit count
  always_comb begin
    hit_cnt_next = hit_cnt;
    if (step && ref_hit && (hit_cnt != HITS_MAX)) begin
      hit_cnt_next = hit_cnt + HITS_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hit_cnt <= '0;
      done    <= 1'b0;
    end else begin
      hit_cnt <= hit_cnt_next;
      done    <= step;
    end
  end

  // result payload, captured with the transfer
  always_ff @(posedge clk) begin
    if (step) begin
      hit           <= ref_hit;
      slot          <= slot_wide[SLOT_W-1:0];
      evicted_valid <= full_miss;
      evicted_page  <= full_miss ? PAGE_W'(cell_pg[0]) : '0;
    end
  end

  assign hit_total = hit_cnt;

endmodule

FILE: sim/page_replace_fifo_lru_core_tb.sv
module page_replace_fifo_lru_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import prfl_pkg::*;

  localparam int FRAMES     = 8;
  localparam int PAGE_COUNT = 256;

  // one result transfer as the block should report it
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [HITS_W-1:0] hit_total;
  } page_outcome_t;

  // block ports; the inputs are known from time zero
  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [PAGE_W-1:0] page = '0;
  logic              cfg_we = 1'b0;
  cfg_reg_t          cfg_idx = REG_POLICY;
  logic [CFG_W-1:0]  cfg_data = '0;
  logic              done;
  logic              hit;
  logic [SLOT_W-1:0] slot;
  logic              evicted_valid;
  logic [PAGE_W-1:0] evicted_page;
  logic [HITS_W-1:0] hit_total;

  // shadow copy of the replacement stack and its registers
  logic              shadow_policy = POLICY_LRU;
  logic [CFG_W-1:0]  shadow_frames = 4'd8;
  logic [PAGE_W-1:0] shadow_pages [FRAMES] = '{default: '0};
  logic              shadow_valid [FRAMES] = '{default: 1'b0};
  logic [HITS_W-1:0] shadow_hits = '0;

  page_outcome_t pending_outcomes [$];

  int fail_count   = 0;
  int refs_sent    = 0;
  int outcomes_got = 0;
  int reg_writes   = 0;
  bit gaps_on      = 1'b0;

  page_replace_fifo_lru_core #(
    .FRAMES    (FRAMES),
    .PAGE_COUNT(PAGE_COUNT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .page         (page),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .done         (done),
    .hit          (hit),
    .slot         (slot),
    .evicted_valid(evicted_valid),
    .evicted_page (evicted_page),
    .hit_total    (hit_total)
  );

  always #10 clk = ~clk;

  // frame count as the stack sees it: zero acts as one, above FRAMES clamps
  function automatic int usable_frames();
    if (shadow_frames == 0) return 1;
    if (shadow_frames > FRAMES) return FRAMES;
    return int'(shadow_frames);
  endfunction

  // apply one page reference to the shadow stack and return the outcome
  function automatic page_outcome_t reference_page(input logic [PAGE_W-1:0] pg);
    page_outcome_t o;
    int n;
    int filled;
    int pos;
    bit found;
    o = '0;
    n = usable_frames();
    filled = 0;
    while (filled < n && shadow_valid[filled]) filled++;
    found = 1'b0;
    pos = 0;
    for (int i = 0; i < filled; i++) begin
      if (!found && shadow_pages[i] == pg) begin
        found = 1'b1;
        pos = i;
      end
    end
    if (found) begin
      if (shadow_hits != HITS_MAX) shadow_hits++;
      if (shadow_policy == POLICY_LRU) begin
        // move to the top of the occupied run, not the top frame
        for (int i = pos; i < filled - 1; i++) shadow_pages[i] = shadow_pages[i+1];
        shadow_pages[filled-1] = pg;
        o.slot = SLOT_W'(filled - 1);
      end else begin
        o.slot = SLOT_W'(pos);
      end
    end else if (filled < n) begin
      shadow_pages[filled] = pg;
      shadow_valid[filled] = 1'b1;
      o.slot = SLOT_W'(filled);
    end else begin
      // full miss: oldest page leaves from slot 0
      o.evicted_valid = 1'b1;
      o.evicted_page  = shadow_pages[0];
      for (int i = 0; i < n - 1; i++) shadow_pages[i] = shadow_pages[i+1];
      shadow_pages[n-1] = pg;
      shadow_valid[n-1] = 1'b1;
      o.slot = SLOT_W'(n - 1);
    end
    o.hit = found;
    o.hit_total = shadow_hits;
    return o;
  endfunction

  function automatic void check_field(input string name, input logic [15:0] want,
                                      input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  // result side: each done strobe is taken at the edge that closes its cycle
  always @(posedge clk) begin : outcome_check
    page_outcome_t want;
    if (!rst && done) begin
      outcomes_got++;
      if (pending_outcomes.size() == 0) begin
        $error("result transfer with no reference outstanding");
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        check_field("hit", 16'(want.hit), 16'(hit));
        check_field("slot", 16'(want.slot), 16'(slot));
        check_field("evicted_valid", 16'(want.evicted_valid), 16'(evicted_valid));
        check_field("evicted_page", 16'(want.evicted_page), 16'(evicted_page));
        check_field("hit_total", 16'(want.hit_total), 16'(hit_total));
      end
    end
  end

  // one reference transfer; start stays up when the next call follows at once
  task automatic send_ref(input logic [PAGE_W-1:0] pg);
    page  <= pg;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pending_outcomes.push_back(reference_page(pg));
    refs_sent++;
    // random sender gap while gaps are on
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
  endtask

  // stop sending and wait for every outstanding result, with a bound
  task automatic drain();
    int waited;
    waited = 0;
    start <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0 && waited < 100) begin
      @(posedge clk);
      waited++;
    end
    if (pending_outcomes.size() != 0) begin
      $error("%0d results never arrived", pending_outcomes.size());
      fail_count++;
      pending_outcomes.delete();
    end
    repeat (3) @(posedge clk);
  endtask

  // register write while the block is idle; cfg_we drops again before the task returns
  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    reg_writes++;
    if (idx == REG_POLICY) begin
      shadow_policy = val[0];
    end else begin
      shadow_frames = val;
      // pages at or above the new count are dropped silently
      for (int i = usable_frames(); i < FRAMES; i++) begin
        shadow_valid[i] = 1'b0;
        shadow_pages[i] = '0;
      end
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // default lru with eight frames: fill every slot, hit, then evict
  task automatic test_lru_fill_evict();
    send_ref(8'h00);
    send_ref(8'hFF);
    send_ref(8'h55);
    send_ref(8'hAA);
    send_ref(8'h01);
    send_ref(8'h02);
    send_ref(8'h03);
    send_ref(8'h04);
    send_ref(8'h00);
    send_ref(8'h09);
    drain();
  endtask

  // zero frames acts as one; then a clamped large count leaves free frames,
  // so an lru hit must land at the top of the occupied run
  task automatic test_lru_hit_free_frames();
    write_reg(REG_FRAMES, 4'd0);
    write_reg(REG_FRAMES, 4'd15);
    send_ref(8'h33);
    send_ref(shadow_pages[0]);
    drain();
  endtask

  // fifo selected through bit 0 only; hits never move pages
  task automatic test_fifo_no_move();
    write_reg(REG_POLICY, {3'b001, POLICY_FIFO});
    write_reg(REG_FRAMES, 4'd3);
    send_ref(8'h40);
    send_ref(shadow_pages[0]);
    send_ref(8'h41);
    send_ref(8'h40);
    drain();
  endtask

  // a single frame: every new page evicts the one before it
  task automatic test_single_frame();
    write_reg(REG_POLICY, {3'b111, POLICY_LRU});
    write_reg(REG_FRAMES, 4'd1);
    send_ref(8'h80);
    send_ref(8'h80);
    send_ref(8'h7F);
    drain();
  endtask

  // random reference streams over small working sets, random settings
  task automatic test_random_mix(input int phases, input int refs_per_phase,
                                 input bit last_quiet);
    logic [PAGE_W-1:0] base;
    int pool;
    int fr;
    for (int ph = 0; ph < phases; ph++) begin
      drain();
      if (ph == 0 || $urandom_range(0, 1) == 0)
        write_reg(REG_POLICY, CFG_W'($urandom_range(0, 15)));
      if (ph == 0 || $urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 5))
          0: fr = 0;
          1: fr = 1;
          2: fr = 8;
          3: fr = 15;
          default: fr = $urandom_range(0, 15);
        endcase
        write_reg(REG_FRAMES, CFG_W'(fr));
      end
      gaps_on = (last_quiet && ph == phases - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      base = PAGE_W'($urandom);
      pool = $urandom_range(1, 12);
      for (int k = 0; k < refs_per_phase; k++) begin
        if ($urandom_range(0, 3) != 0)
          send_ref(base + PAGE_W'($urandom_range(0, pool - 1)));
        else
          send_ref(PAGE_W'($urandom));
      end
    end
    gaps_on = 1'b0;
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_lru_fill_evict();
    test_lru_hit_free_frames();
    test_fifo_no_move();
    test_single_frame();
    test_random_mix(8, 91, 1'b1);

    repeat (5) @(posedge clk);
    $display("covered %0d page references, %0d results checked, %0d register writes",
             refs_sent, outcomes_got, reg_writes);
    $display("fifo and lru policies, frame counts 0 to 15, fills, hits and evictions");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // watchdog well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
